// File: hdl/ndie_pkg.sv
// Shared constants and types for the decimal integer extractor.
package ndie_pkg;

    localparam int CHAR_WIDTH  = 8;
    localparam int INDEX_WIDTH = 8;
    localparam int OUT_WIDTH   = 32;
    localparam int START_WIDTH = 9;
    localparam int DIGIT_WIDTH = 4;

    localparam logic [START_WIDTH-1:0] START_MAX = '1;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CHAR_WIDTH-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] DIGIT_COUNT = 8'd10;

    // Outcome flags of one string, handed from the scanner to the result path.
    typedef struct packed {
        logic found;
        logic negative;
    } t_fin_flags;

    function automatic logic is_delim(input logic [CHAR_WIDTH-1:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_COMMA) || (c == CHAR_SEMI);
    endfunction

endpackage

// File: hdl/ndie_scanner.sv
// Per-character scan state: start detection, index match and digit accumulation.
module ndie_scanner #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [ndie_pkg::CHAR_WIDTH-1:0]   i_char,
    input  logic                              i_last,
    input  logic [ndie_pkg::INDEX_WIDTH-1:0]  i_field_index,
    output logic [VALUE_WIDTH-1:0]            o_fin_acc,
    output ndie_pkg::t_fin_flags              o_fin_flags
);

    typedef enum logic [1:0] {
        PH_SEARCH  = 2'd0,
        PH_COLLECT = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    logic [ndie_pkg::CHAR_WIDTH-1:0]  r_prev, r_prev2;
    logic [1:0]                       r_pos;
    logic [ndie_pkg::START_WIDTH-1:0] r_starts, n_starts;
    logic [VALUE_WIDTH-1:0]           r_acc, n_acc;
    logic                             r_neg, n_neg;
    t_phase                           r_phase, n_phase;

    logic [ndie_pkg::CHAR_WIDTH-1:0]  diff;
    logic                             dig, start;
    logic [VALUE_WIDTH-1:0]           digit_ext;

    always_comb begin
        diff      = i_char - ndie_pkg::CHAR_ZERO;
        dig       = diff < ndie_pkg::DIGIT_COUNT;
        digit_ext = VALUE_WIDTH'(diff[ndie_pkg::DIGIT_WIDTH-1:0]);
        start     = dig && ((r_pos == 2'd0) || ndie_pkg::is_delim(r_prev) ||
                    ((r_prev == ndie_pkg::CHAR_MINUS) &&
                     ((r_pos == 2'd1) || ndie_pkg::is_delim(r_prev2))));
    end

    always_comb begin
        n_starts = r_starts;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_phase  = r_phase;
        case (r_phase)
            PH_SEARCH: begin
                if (start) begin
                    if (r_starts == {1'b0, i_field_index}) begin
                        n_phase = PH_COLLECT;
                        n_neg   = (r_pos != 2'd0) && (r_prev == ndie_pkg::CHAR_MINUS);
                        n_acc   = digit_ext;
                    end else if (r_starts != ndie_pkg::START_MAX) begin
                        n_starts = r_starts + 1'b1;
                    end
                end
            end
            PH_COLLECT: begin
                if (dig) begin
                    n_acc = (r_acc << 3) + (r_acc << 1) + digit_ext;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // Final values of the string, valid in the cycle its last character is accepted.
    assign o_fin_acc            = n_acc;
    assign o_fin_flags.found    = (n_phase != PH_SEARCH);
    assign o_fin_flags.negative = n_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_prev   <= '0;
            r_prev2  <= '0;
            r_pos    <= '0;
            r_starts <= '0;
            r_acc    <= '0;
            r_neg    <= 1'b0;
            r_phase  <= PH_SEARCH;
        end else if (i_accept) begin
            r_prev2  <= r_prev;
            r_prev   <= i_char;
            r_pos    <= (r_pos == 2'd2) ? r_pos : r_pos + 2'd1;
            r_starts <= n_starts;
            r_acc    <= n_acc;
            r_neg    <= n_neg;
            r_phase  <= n_phase;
        end
    end

endmodule

// File: hdl/nth_decimal_integer_extractor.sv
// Top level: picks the configured decimal integer out of a character stream.
// A string's result is registered in the finish stage and then in the output stage.
// Throughput: one character per cycle while o_s_tready is high; the scan state updates in the accept cycle.
// Output backpressure stalls input only once both the finish and output stages are full.
// Reset (i_rst_n low, synchronous) clears scan state, both stages and field_index to 0.
// The block keeps the field index across strings; each string resets the scan state.
module nth_decimal_integer_extractor #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // character stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [ndie_pkg::CHAR_WIDTH-1:0]   i_s_tdata,   // [7:0] character
    input  logic                              i_s_tlast,   // last character of the string
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [ndie_pkg::OUT_WIDTH-1:0]    o_m_tdata,   // [31:0] value (signed)
    output logic                              o_m_tuser,   // [0] found
    // field index register
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ndie_pkg::INDEX_WIDTH-1:0]  i_cfg_data
);

    localparam int CopyW = (VALUE_WIDTH < ndie_pkg::OUT_WIDTH) ?
                           VALUE_WIDTH : ndie_pkg::OUT_WIDTH;

    logic [ndie_pkg::INDEX_WIDTH-1:0] r_field_index;

    logic                       accept, s2_free, s1_move;
    logic [VALUE_WIDTH-1:0]     fin_acc;
    ndie_pkg::t_fin_flags       fin_flags;

    // Finish stage: holds the raw magnitude and flags of a completed string.
    logic                       r_s1_valid;
    logic [VALUE_WIDTH-1:0]     r_s1_acc;
    ndie_pkg::t_fin_flags       r_s1_flags;

    // Output stage.
    logic                       r_out_valid;
    logic [ndie_pkg::OUT_WIDTH-1:0] r_out_value, n_out_value;
    logic                       r_out_found;
    logic [VALUE_WIDTH-1:0]     signed_acc;

    // Config writes must only be issued while idle; the block does not enforce this and always takes them.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_index <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_field_index <= i_cfg_data;
        end
    end

    // Advance the finish stage when the output stage is empty or being drained.
    assign s2_free    = !r_out_valid || i_m_tready;
    assign s1_move    = r_s1_valid && s2_free;
    assign o_s_tready = !r_s1_valid || s1_move;
    assign accept     = i_s_tvalid && o_s_tready;

    ndie_scanner #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_scanner (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_char        (i_s_tdata),
        .i_last        (i_s_tlast),
        .i_field_index (r_field_index),
        .o_fin_acc     (fin_acc),
        .o_fin_flags   (fin_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept && i_s_tlast) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_s_tlast) begin
            r_s1_acc   <= fin_acc;
            r_s1_flags <= fin_flags;
        end
    end

    // Negate and fit the result to the output width; drop to 0 when not found.
    always_comb begin
        signed_acc  = r_s1_flags.negative ? (VALUE_WIDTH'(0) - r_s1_acc) : r_s1_acc;
        n_out_value = r_s1_flags.found ?
                      ndie_pkg::OUT_WIDTH'(signed_acc[CopyW-1:0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_value <= n_out_value;
            r_out_found <= r_s1_flags.found;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_found;

    // A last character always lands in the finish stage.
    a_last_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_s_tlast |=> r_s1_valid)
        else $error("finish stage empty after last character");

    // A blocked finish stage keeps its contents.
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_free |=> r_s1_valid && $stable(r_s1_acc) && $stable(r_s1_flags))
        else $error("finish stage lost or changed while blocked");

    // A moved result shows up on the output.
    a_move_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move |=> r_out_valid)
        else $error("result moved but output not valid");

    // A result that was not found carries value zero.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> r_out_value == '0)
        else $error("nonzero value on a not-found result");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the decimal integer extractor: directed strings, then random ones.
module tb_top;

    // Worst case is about 1400 characters, each with a random input gap, plus random result stalls.
    // Allow several times that.
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;      // two-stage result path plus margin
    localparam int REPORT_MAX = 10;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_CHARS = 125;

    // Table shorthand for bytes that a string literal cannot hold.
    localparam logic [ndie_pkg::CHAR_WIDTH-1:0] NUL_MARK = 8'h23;   // '#' stands for 8'h00
    localparam logic [ndie_pkg::CHAR_WIDTH-1:0] TOP_MARK = 8'h40;   // '@' stands for 8'hFF

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_COLLECT,
        PH_DONE
    } t_scan_phase;

    typedef struct packed {
        logic [ndie_pkg::OUT_WIDTH-1:0] value;
        logic                           found;
    } t_extract;

    typedef struct {
        string                            txt;
        logic [ndie_pkg::INDEX_WIDTH-1:0] idx;
        int                               cut;       // position of a mid-string index write
        logic [ndie_pkg::INDEX_WIDTH-1:0] idx_mid;
        bit                               typed;     // expected result given below
        t_extract                         want;
    } t_dir_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_tvalid = 1'b0;
    logic                             o_s_tready;
    logic [ndie_pkg::CHAR_WIDTH-1:0]  i_s_tdata = '0;
    logic                             i_s_tlast = 1'b0;
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [ndie_pkg::OUT_WIDTH-1:0]   o_m_tdata;
    logic                             o_m_tuser;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [ndie_pkg::INDEX_WIDTH-1:0] i_cfg_data = '0;

    nth_decimal_integer_extractor #(
        .VALUE_WIDTH(32)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Predictor copy of the block state.
    logic [ndie_pkg::INDEX_WIDTH-1:0] field_idx;
    logic [ndie_pkg::CHAR_WIDTH-1:0]  last1, last2;
    logic [1:0]                       seen_n;
    logic [ndie_pkg::START_WIDTH-1:0] starts_n;
    logic [ndie_pkg::OUT_WIDTH-1:0]   mag;
    logic                             neg_f;
    t_scan_phase                      scan_ph;

    t_extract                        pending_picks[$];
    logic [ndie_pkg::CHAR_WIDTH-1:0] text[$];

    bit sender_idle = 1'b0;
    bit quiet = 1'b0;
    int mismatches = 0;
    int n_chars = 0;
    int n_strings = 0;
    int n_checked = 0;
    int n_found = 0;
    int cycle_cnt = 0;

    t_dir_row plan[13] = '{
        '{"7",          8'd0,   0, 8'd0, 1'b1, '{32'd7, 1'b1}},
        '{"#",          8'd0,   0, 8'd0, 1'b1, '{32'd0, 1'b0}},
        '{"@",          8'd0,   0, 8'd0, 1'b1, '{32'd0, 1'b0}},
        '{"-",          8'd0,   0, 8'd0, 1'b1, '{32'd0, 1'b0}},
        '{"-8",         8'd0,   0, 8'd0, 1'b1, '{32'hFFFF_FFF8, 1'b1}},
        '{"a1",         8'd0,   0, 8'd0, 1'b1, '{32'd0, 1'b0}},
        '{"x-1",        8'd0,   0, 8'd0, 1'b1, '{32'd0, 1'b0}},
        '{"12a3",       8'd0,   0, 8'd0, 1'b0, '{32'd0, 1'b0}},
        '{"1 -2",       8'd1,   0, 8'd0, 1'b0, '{32'd0, 1'b0}},
        '{"3,4",        8'd1,   1, 8'd0, 1'b0, '{32'd0, 1'b0}},
        '{"5",          8'd255, 0, 8'd0, 1'b1, '{32'd0, 1'b0}},
        '{"4294967297", 8'd0,   0, 8'd0, 1'b1, '{32'd1, 1'b1}},
        '{"9;-0",       8'd1,   0, 8'd0, 1'b0, '{32'd0, 1'b0}}
    };

    function automatic logic is_sep(input logic [ndie_pkg::CHAR_WIDTH-1:0] c);
        return c == ndie_pkg::CHAR_SPACE || c == ndie_pkg::CHAR_COMMA ||
               c == ndie_pkg::CHAR_SEMI;
    endfunction

    function automatic void wipe_scan();
        last1 = '0;
        last2 = '0;
        seen_n = '0;
        starts_n = '0;
        mag = '0;
        neg_f = 1'b0;
        scan_ph = PH_SEARCH;
    endfunction

    // Advance the predictor by one character; on the last one return the string's result.
    function automatic void scan_char(input logic [ndie_pkg::CHAR_WIDTH-1:0] c,
                                      input logic lst,
                                      output logic emit, output t_extract r);
        logic [ndie_pkg::CHAR_WIDTH-1:0] d;
        logic                            dig;
        logic                            hit;
        d = c - ndie_pkg::CHAR_ZERO;
        dig = d < ndie_pkg::DIGIT_COUNT;
        hit = 1'b0;
        if (dig) begin
            if (seen_n == 2'd0)
                hit = 1'b1;
            else if (is_sep(last1))
                hit = 1'b1;
            else if (last1 == ndie_pkg::CHAR_MINUS && (seen_n == 2'd1 || is_sep(last2)))
                hit = 1'b1;
        end
        case (scan_ph)
            PH_SEARCH: begin
                if (hit) begin
                    if (starts_n == {1'b0, field_idx}) begin
                        scan_ph = PH_COLLECT;
                        neg_f = (seen_n != 2'd0) && (last1 == ndie_pkg::CHAR_MINUS);
                        mag = ndie_pkg::OUT_WIDTH'(d);
                    end else if (starts_n != ndie_pkg::START_MAX) begin
                        starts_n = starts_n + 1'b1;
                    end
                end
            end
            PH_COLLECT: begin
                if (dig)
                    mag = mag * 32'd10 + ndie_pkg::OUT_WIDTH'(d);
                else
                    scan_ph = PH_DONE;
            end
            default: ;
        endcase
        last2 = last1;
        last1 = c;
        if (seen_n != 2'd2)
            seen_n = seen_n + 1'b1;
        emit = lst;
        r = '0;
        if (lst) begin
            if (scan_ph != PH_SEARCH)
                r = '{neg_f ? -mag : mag, 1'b1};
            wipe_scan();
        end
    endfunction

    function automatic logic [ndie_pkg::CHAR_WIDTH-1:0] pick_sep();
        case ($urandom_range(0, 2))
            0: return ndie_pkg::CHAR_SPACE;
            1: return ndie_pkg::CHAR_COMMA;
            default: return ndie_pkg::CHAR_SEMI;
        endcase
    endfunction

    // Hand one character over; keep tvalid high into the next call unless a gap is drawn.
    task automatic put_char(input logic [ndie_pkg::CHAR_WIDTH-1:0] c, input logic lst,
                            output logic emit, output t_extract r);
        if (sender_idle && !quiet && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= c;
        i_s_tlast <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        n_chars++;
        scan_char(c, lst, emit, r);
    endtask

    // Drop the input, wait for every pending result, then let the pipeline drain.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_index(input logic [ndie_pkg::INDEX_WIDTH-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        field_idx = v;
    endtask

    // Send the text buffer as one string; optionally rewrite the index partway through.
    task automatic send_text(input int cut, input logic [ndie_pkg::INDEX_WIDTH-1:0] idx_mid,
                             input bit typed, input t_extract want);
        logic     emit;
        t_extract r;
        for (int i = 0; i < text.size(); i++) begin
            if (cut != 0 && i == cut) begin
                settle();
                load_index(idx_mid);
            end
            put_char(text[i], i == text.size() - 1, emit, r);
            if (emit) begin
                if (typed)
                    r = want;
                pending_picks.push_back(r);
                n_strings++;
                if (r.found)
                    n_found++;
            end
        end
    endtask

    // Build a random string: mostly delimited number lists, some sloppy ones, some raw noise.
    task automatic build_line();
        int kind;
        int nd;
        bit sloppy;
        text.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            repeat ($urandom_range(1, 10)) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            sloppy = (kind >= 70);
            if ($urandom_range(0, 4) == 0)
                text.push_back(pick_sep());
            for (int t = 0; t < $urandom_range(1, 8); t++) begin
                if (t != 0) begin
                    if (sloppy && $urandom_range(0, 1) == 1)
                        text.push_back(8'($urandom_range(0, 255)));
                    else
                        repeat ($urandom_range(1, 2)) text.push_back(pick_sep());
                end
                if ($urandom_range(0, 3) != 0) begin
                    if ($urandom_range(0, 4) < 2)
                        text.push_back(ndie_pkg::CHAR_MINUS);
                    if (sloppy && $urandom_range(0, 3) == 0)
                        text.push_back(ndie_pkg::CHAR_MINUS);
                    nd = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12)
                                                      : $urandom_range(1, 4);
                    repeat (nd)
                        text.push_back(ndie_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
                end else begin
                    repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(33, 126)));
                end
            end
            if ($urandom_range(0, 4) == 0)
                text.push_back(pick_sep());
        end
    endtask

    task automatic flag_mismatch(input string what, input t_extract want,
                                 input logic [ndie_pkg::OUT_WIDTH-1:0] got_v,
                                 input logic got_f);
        if (mismatches < REPORT_MAX)
            $display("mismatch %0d: %s, expected value=%0d found=%b, got value=%0d found=%b",
                     mismatches, what, $signed(want.value), want.found,
                     $signed(got_v), got_f);
        mismatches++;
    endtask

    // Result side: random stall bursts, occasional calm stretches, none at the end.
    initial begin : sink_side
        int stall_left;
        int calm_left;
        stall_left = 0;
        calm_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                if (stall_left == 0)
                    i_m_tready <= 1'b1;
            end else if (calm_left > 0 || quiet) begin
                if (calm_left > 0)
                    calm_left--;
                i_m_tready <= 1'b1;
            end else if ($urandom_range(0, 29) == 0) begin
                calm_left = $urandom_range(50, 200);
                i_m_tready <= 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 12);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest pending expectation.
    always @(posedge i_clk) begin : result_check
        t_extract want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            n_checked++;
            if (pending_picks.size() == 0) begin
                flag_mismatch("result with nothing pending", '0, o_m_tdata, o_m_tuser);
            end else begin
                want = pending_picks.pop_front();
                if (o_m_tdata != want.value || o_m_tuser != want.found)
                    flag_mismatch("wrong result", want, o_m_tdata, o_m_tuser);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("watchdog: run stalled, %0d results still pending", pending_picks.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [ndie_pkg::CHAR_WIDTH-1:0]  ch;
        logic [ndie_pkg::INDEX_WIDTH-1:0] pick;
        int                               phase_chars;
        field_idx = '0;
        wipe_scan();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed strings: extremes, stray minus signs, odd bytes, overflow, mid-string write.
        foreach (plan[r]) begin
            if (r == 0 || plan[r].idx != field_idx) begin
                settle();
                load_index(plan[r].idx);
            end
            text.delete();
            for (int k = 0; k < plan[r].txt.len(); k++) begin
                ch = plan[r].txt[k];
                if (ch == NUL_MARK)
                    ch = 8'h00;
                else if (ch == TOP_MARK)
                    ch = 8'hFF;
                text.push_back(ch);
            end
            send_text(plan[r].cut, plan[r].idx_mid, plan[r].typed, plan[r].want);
        end

        // Random phases, each under its own index setting; the last one runs without idling.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: pick = 8'd0;
                1: pick = 8'd1;
                2: pick = 8'($urandom_range(0, 255));
                3: pick = 8'd2;
                4: pick = 8'd255;
                default: pick = 8'($urandom_range(0, 3));
            endcase
            settle();
            load_index(pick);
            quiet = (p == PHASE_COUNT - 1);
            phase_chars = 0;
            if (pick == 8'd255) begin
                // Reach the highest index: 255 single digits, then a negative two-digit one.
                text.delete();
                for (int k = 0; k < 255; k++) begin
                    text.push_back(ndie_pkg::CHAR_ZERO + 8'(k % 10));
                    text.push_back(pick_sep());
                end
                text.push_back(ndie_pkg::CHAR_MINUS);
                text.push_back(ndie_pkg::CHAR_ZERO + 8'd9);
                text.push_back(ndie_pkg::CHAR_ZERO + 8'd7);
                sender_idle = 1'b1;
                send_text(0, '0, 1'b0, '0);
            end
            while (phase_chars < PHASE_CHARS) begin
                build_line();
                sender_idle = ($urandom_range(0, 3) != 0);
                send_text(0, '0, 1'b0, '0);
                phase_chars += text.size();
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (2 * SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d strings, %0d characters, %0d results compared, %0d found",
                 n_strings, n_chars, n_checked, n_found);
        $display("index settings 0, 1, 2, 255 and random; %0d mismatches", mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
hdl/ndie_pkg.sv
hdl/ndie_scanner.sv
hdl/nth_decimal_integer_extractor.sv
sim/tb_top.sv
